// ===== hdl/integer_to_text_formatter_assert.svh =====
// Assertion macros of the integer-to-text formatter RTL, used by its controller.
// Include this file inside a module body; it depends on nothing else.
`ifndef INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH
`define INTEGER_TO_TEXT_FORMATTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/itf_pkg.sv =====
// Shared types, constants and helper functions of the integer-to-text formatter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package itf_pkg;

    // Field widths of the request and of one result character.
    localparam int VALUE_W    = 64;
    localparam int MODE_W     = 2;
    localparam int WIDTH_W    = 6;
    localparam int CHAR_W     = 8;

    // Digit buffer: enough digits for a 64-bit value in octal.
    localparam int NUM_DIGITS = 22;
    localparam int DIGIT_W    = 4;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CONV_W     = $clog2(VALUE_W + 1);

    // Default field width limit.
    localparam int MAX_FIELD_DEF = 40;

    // Base selection codes; any other code formats as hexadecimal.
    localparam logic [MODE_W-1:0] MODE_OCT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEC = 2'd1;

    // ASCII codes used by the field builder.
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;

    // Which character source the datapath drives into the output register.
    typedef enum logic [2:0] {
        SEL_SPACE = 3'd0,
        SEL_SIGN  = 3'd1,
        SEL_ZERO  = 3'd2,
        SEL_X     = 3'd3,
        SEL_DIGIT = 3'd4
    } t_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv;
        logic size;
        logic plan;
        logic emit;
        t_sel sel;
        logic last;
        logic dec_sp;
        logic dec_zp;
        logic dec_idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_decimal;
        logic conv_last;
        logic sp_zero;
        logic sp_one;
        logic zp_zero;
        logic zp_one;
        logic idx_zero;
        logic has_sign;
        logic has_prefix;
        logic left;
        logic out_free;
    } t_status;

    // ASCII character for one digit value.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            return CH_ZERO + ext;
        end else if (upper) begin
            return CH_A_UP - 8'd10 + ext;
        end else begin
            return CH_A_LO - 8'd10 + ext;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/itf_ctrl.sv =====
// Controller state machine of the integer-to-text formatter.
// Sequences conversion, planning and emission; uses itf_pkg and the assertion header.
`default_nettype none

module itf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire itf_pkg::t_status i_status,
    output itf_pkg::t_cmd         o_cmd
);
    import itf_pkg::*;

    `include "integer_to_text_formatter_assert.svh"

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CONV  = 11'b000_0000_0010,
        S_SIZE  = 11'b000_0000_0100,
        S_PLAN  = 11'b000_0000_1000,
        S_LEAD  = 11'b000_0001_0000,
        S_SIGN  = 11'b000_0010_0000,
        S_PFX0  = 11'b000_0100_0000,
        S_PFXX  = 11'b000_1000_0000,
        S_ZERO  = 11'b001_0000_0000,
        S_DIGIT = 11'b010_0000_0000,
        S_TRAIL = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands. Each emitting state waits for a free output register.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = SEL_SPACE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.in_decimal ? S_CONV : S_SIZE;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_status.conv_last) begin
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                o_cmd.size = 1'b1;
                n_state    = S_PLAN;
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = S_LEAD;
            end
            S_LEAD: begin
                if (i_status.left || i_status.sp_zero) begin
                    n_state = S_SIGN;
                end else if (i_status.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.sel    = SEL_SPACE;
                    o_cmd.dec_sp = 1'b1;
                    if (i_status.sp_one) begin
                        n_state = S_SIGN;
                    end
                end
            end
            S_SIGN: begin
                if (!i_status.has_sign) begin
                    n_state = S_PFX0;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_SIGN;
                    n_state    = S_PFX0;
                end
            end
            S_PFX0: begin
                if (!i_status.has_prefix) begin
                    n_state = S_ZERO;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_ZERO;
                    n_state    = S_PFXX;
                end
            end
            S_PFXX: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = SEL_X;
                    n_state    = S_ZERO;
                end
            end
            S_ZERO: begin
                if (i_status.zp_zero) begin
                    n_state = S_DIGIT;
                end else if (i_status.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.sel    = SEL_ZERO;
                    o_cmd.dec_zp = 1'b1;
                    if (i_status.zp_one) begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.sel     = SEL_DIGIT;
                    o_cmd.dec_idx = 1'b1;
                    o_cmd.last    = i_status.idx_zero &&
                                    (!i_status.left || i_status.sp_zero);
                    if (i_status.idx_zero) begin
                        n_state = (i_status.left && !i_status.sp_zero) ? S_TRAIL : S_IDLE;
                    end
                end
            end
            S_TRAIL: begin
                if (i_status.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.sel    = SEL_SPACE;
                    o_cmd.dec_sp = 1'b1;
                    o_cmd.last   = i_status.sp_one;
                    if (i_status.sp_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A new request is taken only between fields.
    assign o_stall = (r_state != S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A character is only written into a free output register.
    `ITF_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_status.out_free, "emit into busy output")
    // The final character of a field returns the controller to idle.
    `ITF_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_cmd.emit && o_cmd.last, r_state == S_IDLE, "last char not followed by idle")
    // An accepted request always starts work on the next cycle.
    `ITF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, r_state != S_IDLE, "accepted request left idle")
    // Nothing is emitted while the block is idle.
    `ITF_ASSERT_SAME(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !o_cmd.emit, "emit while idle")

endmodule

`default_nettype wire

// ===== hdl/itf_datapath.sv =====
// Datapath of the integer-to-text formatter: magnitude, digit buffer with BCD
// conversion, field planning counters and the output register. Uses itf_pkg.
`default_nettype none

module itf_datapath #(
    parameter int MAX_FIELD = itf_pkg::MAX_FIELD_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic signed [itf_pkg::VALUE_W-1:0] i_value,
    input  wire logic [itf_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [itf_pkg::WIDTH_W-1:0]   i_min_width,
    input  wire logic [itf_pkg::WIDTH_W-1:0]   i_precision,
    input  wire logic                          i_left_justify,
    input  wire logic                          i_force_plus,
    input  wire logic                          i_space_sign,
    input  wire logic                          i_alt_prefix,
    input  wire logic                          i_zero_pad,
    input  wire logic                          i_upper_case,
    input  wire logic                          i_unsigned_value,
    input  wire itf_pkg::t_cmd                 i_cmd,
    output itf_pkg::t_status                   o_status,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic [itf_pkg::CHAR_W-1:0]         o_character,
    output logic                               o_last_char
);
    import itf_pkg::*;

    localparam int CntW  = $clog2(MAX_FIELD + 1);
    localparam int CalcW = CntW + 1;

    // Captured request fields.
    logic [VALUE_W-1:0]  r_mag;
    logic [DIGIT_W-1:0]  r_digits [NUM_DIGITS];
    logic [CONV_W-1:0]   r_conv_cnt;
    logic [CntW-1:0]     r_minw;
    logic [CntW-1:0]     r_prec;
    logic                r_left;
    logic                r_prefix;
    logic                r_zpad;
    logic                r_upper;
    logic                r_has_sign;
    logic [CHAR_W-1:0]   r_sign_char;

    // Field plan: padding spaces, zeros, and the index of the digit to send.
    logic [CntW-1:0]     r_sp;
    logic [CntW-1:0]     r_zp;
    logic [IDX_W-1:0]    r_idx;

    // Output register.
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic                r_out_last;

    logic [VALUE_W-1:0]  load_mag;
    logic                load_neg;
    logic [VALUE_W+1:0]  mag_ext;
    logic [DIGIT_W-1:0]  load_digits [NUM_DIGITS];
    logic [DIGIT_W-1:0]  adj_digits [NUM_DIGITS];
    logic [DIGIT_W-1:0]  conv_digits [NUM_DIGITS];
    logic [IDX_W-1:0]    msd_idx;
    logic [CalcW-1:0]    place;
    logic [CalcW-1:0]    prec_c;
    logic [CalcW-1:0]    minw_c;
    logic [CalcW-1:0]    body;
    logic [CalcW-1:0]    zp0;
    logic [CalcW-1:0]    need;
    logic [CalcW-1:0]    sp0;
    logic [CalcW-1:0]    plan_sp;
    logic [CalcW-1:0]    plan_zp;
    logic [CHAR_W-1:0]   emit_char;
    logic                out_free;

    // Width limit applied to the requested widths.
    function automatic logic [CntW-1:0] sat_width(input logic [WIDTH_W-1:0] w);
        if (w > WIDTH_W'(MAX_FIELD)) begin
            return CntW'(MAX_FIELD);
        end else begin
            return CntW'(w);
        end
    endfunction

    // Magnitude of the request and the direct octal or hex digit split.
    always_comb begin
        load_neg = !i_unsigned_value && i_value[VALUE_W-1];
        load_mag = load_neg ? (VALUE_W'(0) - i_value) : i_value;
        mag_ext  = {2'b00, load_mag};
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (i_mode == MODE_OCT) begin
                load_digits[k] = {1'b0, mag_ext[3*k +: 3]};
            end else if (i_mode == MODE_DEC) begin
                load_digits[k] = '0;
            end else if (k < VALUE_W / DIGIT_W) begin
                load_digits[k] = mag_ext[DIGIT_W*k +: DIGIT_W];
            end else begin
                load_digits[k] = '0;
            end
        end
    end

    // One shift-and-add-3 step of the binary to BCD conversion.
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            adj_digits[k] = (r_digits[k] >= 4'd5) ? (r_digits[k] + 4'd3) : r_digits[k];
        end
        conv_digits[0] = {adj_digits[0][DIGIT_W-2:0], r_mag[VALUE_W-1]};
        for (int k = 1; k < NUM_DIGITS; k++) begin
            conv_digits[k] = {adj_digits[k][DIGIT_W-2:0], adj_digits[k-1][DIGIT_W-1]};
        end
    end

    // Position of the most significant nonzero digit; zero keeps one digit.
    always_comb begin
        msd_idx = '0;
        for (int k = 1; k < NUM_DIGITS; k++) begin
            if (r_digits[k] != '0) begin
                msd_idx = IDX_W'(k);
            end
        end
    end

    // Field plan from the digit count, precision, sign, prefix and width.
    always_comb begin
        place  = CalcW'(r_idx) + CalcW'(1);
        prec_c = CalcW'(r_prec);
        minw_c = CalcW'(r_minw);
        body   = (prec_c > place) ? prec_c : place;
        zp0    = (prec_c > place) ? (prec_c - place) : '0;
        need   = body + CalcW'(r_has_sign) + (r_prefix ? CalcW'(2) : CalcW'(0));
        sp0    = (minw_c > need) ? (minw_c - need) : '0;
        if (r_zpad) begin
            plan_zp = (sp0 > zp0) ? sp0 : zp0;
            plan_sp = '0;
        end else begin
            plan_zp = zp0;
            plan_sp = sp0;
        end
    end

    // Character source selection.
    always_comb begin
        case (i_cmd.sel)
            SEL_SPACE: emit_char = CH_SPACE;
            SEL_SIGN:  emit_char = r_sign_char;
            SEL_ZERO:  emit_char = CH_ZERO;
            SEL_X:     emit_char = CH_X;
            SEL_DIGIT: emit_char = digit_char(r_digits[r_idx], r_upper);
            default:   emit_char = CH_SPACE;
        endcase
    end

    assign out_free = !r_out_valid || !i_stall;

    // Request capture, conversion and planning registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag      <= load_mag;
            r_digits   <= load_digits;
            r_conv_cnt <= CONV_W'(VALUE_W);
            r_minw     <= sat_width(i_min_width);
            r_prec     <= sat_width(i_precision);
            r_left     <= i_left_justify;
            r_prefix   <= i_alt_prefix;
            r_zpad     <= i_zero_pad;
            r_upper    <= i_upper_case;
            r_has_sign <= !i_unsigned_value && (load_neg || i_force_plus || i_space_sign);
            if (load_neg) begin
                r_sign_char <= CH_MINUS;
            end else if (i_force_plus) begin
                r_sign_char <= CH_PLUS;
            end else begin
                r_sign_char <= CH_SPACE;
            end
        end else if (i_cmd.conv) begin
            r_digits   <= conv_digits;
            r_mag      <= {r_mag[VALUE_W-2:0], 1'b0};
            r_conv_cnt <= r_conv_cnt - CONV_W'(1);
        end
        if (i_cmd.size) begin
            r_idx <= msd_idx;
        end else if (i_cmd.dec_idx) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        if (i_cmd.plan) begin
            r_sp <= CntW'(plan_sp);
            r_zp <= CntW'(plan_zp);
        end else begin
            if (i_cmd.dec_sp) begin
                r_sp <= r_sp - CntW'(1);
            end
            if (i_cmd.dec_zp) begin
                r_zp <= r_zp - CntW'(1);
            end
        end
    end

    // Output register: filled on emit, emptied when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= emit_char;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last_char = r_out_last;

    // Status toward the controller.
    always_comb begin
        o_status.in_decimal = (i_mode == MODE_DEC);
        o_status.conv_last  = (r_conv_cnt == CONV_W'(1));
        o_status.sp_zero    = (r_sp == '0);
        o_status.sp_one     = (r_sp == CntW'(1));
        o_status.zp_zero    = (r_zp == '0);
        o_status.zp_one     = (r_zp == CntW'(1));
        o_status.idx_zero   = (r_idx == '0);
        o_status.has_sign   = r_has_sign;
        o_status.has_prefix = r_prefix;
        o_status.left       = r_left;
        o_status.out_free   = out_free;
    end

endmodule

`default_nettype wire

// ===== hdl/integer_to_text_formatter.sv =====
// Top level of the integer-to-text formatter: controller plus datapath.
// Depends on itf_pkg, itf_ctrl and itf_datapath.
//
// Usage: a request (value, base, widths, flags) is offered with i_valid and is
// taken at a clock edge where o_stall is low. The field comes back on the output
// channel as one ASCII character per output word, o_valid framing each and
// o_last_char marking the final character of the field.
// Work per request: capture, then bit-serial binary to BCD conversion for
// decimal (none for octal or hex, whose digits are plain bit groups), then
// sizing the digits and planning the padding, then one character per cycle
// while the output register is free, with up to four empty field sections
// (leading spaces, sign, prefix, zeros) passed over without a character.
// Decimal conversion and empty field sections delay the first character.
// The next request is taken in the cycle after the last character is written,
// even while that character still waits in the output register. A stall from
// the receiver holds the output register and pauses emission. Reset
// (synchronous, active low) empties the output register and idles the controller.
`default_nettype none

module integer_to_text_formatter #(
    parameter int MAX_FIELD = itf_pkg::MAX_FIELD_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [itf_pkg::VALUE_W-1:0] i_value,
    input  wire logic [itf_pkg::MODE_W-1:0]         i_mode,
    input  wire logic [itf_pkg::WIDTH_W-1:0]        i_min_width,
    input  wire logic [itf_pkg::WIDTH_W-1:0]        i_precision,
    input  wire logic                               i_left_justify,
    input  wire logic                               i_force_plus,
    input  wire logic                               i_space_sign,
    input  wire logic                               i_alt_prefix,
    input  wire logic                               i_zero_pad,
    input  wire logic                               i_upper_case,
    input  wire logic                               i_unsigned_value,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [itf_pkg::CHAR_W-1:0]              o_character,
    output logic                                    o_last_char
);
    import itf_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer for conversion, planning and emission.
    itf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Digit buffer, field counters and output register.
    itf_datapath #(
        .MAX_FIELD (MAX_FIELD)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_value          (i_value),
        .i_mode           (i_mode),
        .i_min_width      (i_min_width),
        .i_precision      (i_precision),
        .i_left_justify   (i_left_justify),
        .i_force_plus     (i_force_plus),
        .i_space_sign     (i_space_sign),
        .i_alt_prefix     (i_alt_prefix),
        .i_zero_pad       (i_zero_pad),
        .i_upper_case     (i_upper_case),
        .i_unsigned_value (i_unsigned_value),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_character      (o_character),
        .o_last_char      (o_last_char)
    );

endmodule

`default_nettype wire
